// ----- design/ssrq_pkg.sv -----
// Package for the sequenced slot ring queue.
// Holds sizes, opcode and status codes, and the depth saturation helper.
// No dependencies.
package ssrq_pkg;

    localparam int SLOTS      = 16;
    localparam int IDX_BITS   = $clog2(SLOTS);
    localparam int POS_BITS   = 32;
    localparam int DEPTH_BITS = 5;
    localparam int OP_BITS    = 3;
    localparam int STAT_BITS  = 2;

    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [OP_BITS-1:0]    op_t;
    typedef logic [STAT_BITS-1:0]  stat_t;

    localparam op_t OP_RESERVE = 3'd0;
    localparam op_t OP_PUBLISH = 3'd1;
    localparam op_t OP_TAKE    = 3'd2;
    localparam op_t OP_RELEASE = 3'd3;
    localparam op_t OP_QUERY   = 3'd4;

    localparam stat_t ST_OK    = 2'd0;
    localparam stat_t ST_FULL  = 2'd1;
    localparam stat_t ST_EMPTY = 2'd2;
    localparam stat_t ST_PHASE = 2'd3;

    localparam pos_t   POS_SLOTS = pos_t'(SLOTS);
    localparam pos_t   POS_ONE   = pos_t'(1);
    localparam depth_t DEPTH_SAT = {DEPTH_BITS{1'b1}};

    // Clamp a position difference to the depth field range
    function automatic depth_t sat_depth(input pos_t d);
        depth_t r;
        if (d > pos_t'(DEPTH_SAT))
            r = DEPTH_SAT;
        else
            r = d[DEPTH_BITS-1:0];
        return r;
    endfunction

endpackage

// ----- design/ssrq_if.sv -----
// Channel interfaces for the sequenced slot ring queue: request and response.
// Depends on ssrq_pkg.
interface ssrq_req_if;
    logic                valid;
    logic                ready;
    ssrq_pkg::op_t       opcode;
    ssrq_pkg::idx_t      slot_index;

    modport source (output valid, output opcode, output slot_index, input ready);
    modport sink   (input valid, input opcode, input slot_index, output ready);
endinterface

interface ssrq_rsp_if;
    logic                valid;
    logic                ready;
    ssrq_pkg::stat_t     status;
    ssrq_pkg::idx_t      granted_slot;
    ssrq_pkg::depth_t    depth;
    ssrq_pkg::depth_t    depth_high_water;

    modport source (output valid, output status, output granted_slot, output depth,
                    output depth_high_water, input ready);
    modport sink   (input valid, input status, input granted_slot, input depth,
                    input depth_high_water, output ready);
endinterface

// ----- design/sequenced_slot_ring_queue.sv -----
// Sequenced slot ring queue: a request beat goes into the request register, then
// one pass of logic into the response register. Throughput one request per cycle
// while responses are taken; the response register frees the request side.
// Reset (rst_n, async, active low) zeroes tail, head and high water and sets each
// slot sequence to its own index at once; claimed positions are left unset.
// Depends on ssrq_pkg and the channel interfaces in ssrq_if.sv.
module sequenced_slot_ring_queue
(
    input  logic          clk,
    input  logic          rst_n,
    ssrq_req_if.sink      req,
    ssrq_rsp_if.source    rsp
);
    import ssrq_pkg::*;

    // Request stage
    logic   req_valid_reg;
    op_t    req_op_reg;
    idx_t   req_idx_reg;

    // Queue state
    pos_t   tail_reg, tail_next;
    pos_t   head_reg, head_next;
    depth_t hw_reg, hw_next;
    pos_t   seq_reg [SLOTS];
    pos_t   clm_mem [SLOTS];

    // Response stage
    logic   rsp_valid_reg;
    stat_t  rsp_status_reg, rsp_status_next;
    idx_t   rsp_slot_reg, rsp_slot_next;
    depth_t rsp_depth_reg;
    depth_t rsp_hw_reg;

    logic   fire;
    idx_t   addr;
    pos_t   seq_rd;
    pos_t   clm_rd;
    pos_t   tail_back;
    pos_t   seq_m1;
    pos_t   head_back;
    pos_t   clm_p1;
    depth_t pub_depth;
    logic   reserved_ok;
    logic   taken_ok;
    logic   seq_we;
    pos_t   seq_wdata;
    logic   clm_we;

    // Advance when the response slot is empty or being drained
    assign fire      = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || fire;

    // Capture a request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_op_reg  <= req.opcode;
            req_idx_reg <= req.slot_index;
        end
    end

    // Pick the one slot this request touches
    always_comb
    begin
        unique case (req_op_reg)
            OP_RESERVE: addr = tail_reg[IDX_BITS-1:0];
            OP_TAKE:    addr = head_reg[IDX_BITS-1:0];
            default:    addr = req_idx_reg;
        endcase
    end

    assign seq_rd = seq_reg[addr];
    assign clm_rd = clm_mem[addr];

    // Phase checks; slot_index always lies below SLOTS at this width
    assign tail_back   = tail_reg - seq_rd;
    assign reserved_ok = (seq_rd[IDX_BITS-1:0] == req_idx_reg) && (tail_back != '0)
                         && (tail_back <= POS_SLOTS);
    assign seq_m1      = seq_rd - POS_ONE;
    assign head_back   = head_reg - seq_m1;
    assign taken_ok    = (seq_m1[IDX_BITS-1:0] == req_idx_reg) && (head_back != '0)
                         && (head_back <= POS_SLOTS);
    assign clm_p1      = clm_rd + POS_ONE;
    assign pub_depth   = sat_depth(clm_p1 - head_reg);

    // Decode the request into state updates and a response
    always_comb
    begin
        tail_next       = tail_reg;
        head_next       = head_reg;
        hw_next         = hw_reg;
        seq_we          = 1'b0;
        seq_wdata       = clm_p1;
        clm_we          = 1'b0;
        rsp_status_next = ST_OK;
        rsp_slot_next   = '0;
        unique case (req_op_reg)
            OP_RESERVE:
            begin
                if (seq_rd == tail_reg)
                begin
                    clm_we        = 1'b1;
                    tail_next     = tail_reg + POS_ONE;
                    rsp_slot_next = addr;
                end
                else
                begin
                    rsp_status_next = ST_FULL;
                end
            end
            OP_PUBLISH:
            begin
                if (reserved_ok)
                begin
                    seq_we        = 1'b1;
                    seq_wdata     = clm_p1;
                    if (pub_depth > hw_reg)
                        hw_next = pub_depth;
                    rsp_slot_next = addr;
                end
                else
                begin
                    rsp_status_next = ST_PHASE;
                end
            end
            OP_TAKE:
            begin
                if (seq_rd == (head_reg + POS_ONE))
                begin
                    head_next     = head_reg + POS_ONE;
                    rsp_slot_next = addr;
                end
                else
                begin
                    rsp_status_next = ST_EMPTY;
                end
            end
            OP_RELEASE:
            begin
                if (taken_ok)
                begin
                    seq_we        = 1'b1;
                    seq_wdata     = clm_rd + POS_SLOTS;
                    rsp_slot_next = addr;
                end
                else
                begin
                    rsp_status_next = ST_PHASE;
                end
            end
            default:
            begin
                // query and unused codes change nothing
            end
        endcase
    end

    // Update positions, high water and slot sequences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
            head_reg <= '0;
            hw_reg   <= '0;
            for (int i = 0; i < SLOTS; i++)
                seq_reg[i] <= pos_t'(i);
        end
        else if (fire)
        begin
            tail_reg <= tail_next;
            head_reg <= head_next;
            hw_reg   <= hw_next;
            if (seq_we)
                seq_reg[addr] <= seq_wdata;
        end
    end

    // Record the position a reserve claimed
    always_ff @(posedge clk)
    begin
        if (fire && clm_we)
            clm_mem[addr] <= tail_reg;
    end

    // Hold the response until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_slot_reg   <= rsp_slot_next;
            rsp_depth_reg  <= sat_depth(tail_next - head_next);
            rsp_hw_reg     <= hw_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.granted_slot     = rsp_slot_reg;
    assign rsp.depth            = rsp_depth_reg;
    assign rsp.depth_high_water = rsp_hw_reg;

    // Occupancy never exceeds the ring size
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg - head_reg) <= POS_SLOTS)
        else $error("queue occupancy beyond ring size");

    // High water only rises
    a_hw_mono: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg >= $past(hw_reg))
        else $error("high water decreased");

    // A refused request leaves both positions alone
    a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rsp_status_next != ST_OK) |=> ($stable(tail_reg) && $stable(head_reg)))
        else $error("position moved on a refused request");

    // Reported depth stays within the ring size
    a_rsp_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_depth_reg <= depth_t'(SLOTS)))
        else $error("reported depth beyond ring size");

endmodule

// ----- verif/ssrq_response_checker.sv -----
// Response checker for the sequenced slot ring queue: watches both channels,
// predicts each response from the request beats and compares field by field.
// Depends on ssrq_pkg and the channel interfaces in ssrq_if.sv.
module ssrq_response_checker
(
    input  logic   clk,
    input  logic   rst_n,
    ssrq_req_if    req,
    ssrq_rsp_if    rsp,
    output int     fail_count,
    output int     pending
);
    import ssrq_pkg::*;

    typedef struct packed {
        stat_t  status;
        idx_t   granted_slot;
        depth_t depth;
        depth_t depth_high_water;
    } answer_t;

    // Shadow copy of the ring state
    pos_t    tail_pos;
    pos_t    head_pos;
    pos_t    peak_depth;
    pos_t    seq_tag   [SLOTS];
    pos_t    claim_pos [SLOTS];
    answer_t awaited   [$];
    int      errs;

    // Apply one request to the shadow ring and build the answer it earns
    task automatic serve_request(input op_t op, input idx_t idx, output answer_t ans);
        pos_t seq;
        pos_t back;
        pos_t span;
        idx_t s;
        ans.status       = ST_OK;
        ans.granted_slot = '0;
        case (op)
            OP_RESERVE:
            begin
                s = tail_pos[IDX_BITS-1:0];
                if (seq_tag[s] == tail_pos)
                begin
                    claim_pos[s]     = tail_pos;
                    tail_pos         = tail_pos + POS_ONE;
                    ans.granted_slot = s;
                end
                else
                    ans.status = ST_FULL;
            end
            OP_PUBLISH:
            begin
                seq  = seq_tag[idx];
                back = tail_pos - seq;
                if (seq[IDX_BITS-1:0] == idx && back >= POS_ONE && back <= POS_SLOTS)
                begin
                    span = claim_pos[idx] + POS_ONE - head_pos;
                    if (span > peak_depth)
                        peak_depth = span;
                    seq_tag[idx]     = claim_pos[idx] + POS_ONE;
                    ans.granted_slot = idx;
                end
                else
                    ans.status = ST_PHASE;
            end
            OP_TAKE:
            begin
                s = head_pos[IDX_BITS-1:0];
                if (seq_tag[s] == head_pos + POS_ONE)
                begin
                    head_pos         = head_pos + POS_ONE;
                    ans.granted_slot = s;
                end
                else
                    ans.status = ST_EMPTY;
            end
            OP_RELEASE:
            begin
                seq  = seq_tag[idx] - POS_ONE;
                back = head_pos - seq;
                if (seq[IDX_BITS-1:0] == idx && back >= POS_ONE && back <= POS_SLOTS)
                begin
                    seq_tag[idx]     = claim_pos[idx] + POS_SLOTS;
                    ans.granted_slot = idx;
                end
                else
                    ans.status = ST_PHASE;
            end
            // query and the unused codes change nothing
            default: ;
        endcase
        span = tail_pos - head_pos;
        ans.depth = (span > pos_t'(DEPTH_SAT)) ? DEPTH_SAT : span[DEPTH_BITS-1:0];
        ans.depth_high_water = (peak_depth > pos_t'(DEPTH_SAT)) ?
                               DEPTH_SAT : peak_depth[DEPTH_BITS-1:0];
    endtask

    // Report one field; return 1 on mismatch
    function automatic int field_mismatch(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check response beats against the oldest prediction, then queue new predictions
    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        int      bad;
        if (!rst_n)
        begin
            tail_pos   = '0;
            head_pos   = '0;
            peak_depth = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                seq_tag[i]   = pos_t'(i);
                claim_pos[i] = '0;
            end
            awaited.delete();
            errs       = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    errs++;
                end
                else
                begin
                    want = awaited.pop_front();
                    bad  = 0;
                    bad += field_mismatch("status", want.status, rsp.status);
                    bad += field_mismatch("granted_slot", want.granted_slot, rsp.granted_slot);
                    bad += field_mismatch("depth", want.depth, rsp.depth);
                    bad += field_mismatch("depth_high_water", want.depth_high_water,
                                          rsp.depth_high_water);
                    if (bad != 0)
                        errs++;
                end
            end
            if (req.valid && req.ready)
            begin
                serve_request(req.opcode, req.slot_index, want);
                awaited.push_back(want);
            end
            fail_count <= errs;
            pending    <= awaited.size();
        end
    end

endmodule

// ----- verif/sequenced_slot_ring_queue_tb.sv -----
// Testbench top for the sequenced slot ring queue: drives request beats,
// stalls the response side at random and reports the verdict.
// Depends on ssrq_pkg, ssrq_if.sv, the block and ssrq_response_checker.
module sequenced_slot_ring_queue_tb;
    import ssrq_pkg::*;

    localparam int DIRECTED    = 25;
    localparam int ITEMS       = 1150;
    localparam int CYCLE_LIMIT = 60000;
    localparam int IDLE_PCT    = 11;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    int   cycles = 0;

    // Request bookkeeping used to steer publish and release toward live slots
    op_t  in_flight  [$];
    idx_t to_publish [$];
    idx_t to_release [$];

    ssrq_req_if req_ch ();
    ssrq_rsp_if rsp_ch ();

    sequenced_slot_ring_queue i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ssrq_response_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Opening: empty take, wrong-phase ops, query, unused codes, fill to full
    task automatic directed_item(input int n, output op_t op, output idx_t idx);
        idx = idx_t'(SLOTS - 1);
        if (n == 0)
        begin
            op  = OP_TAKE;
            idx = '0;
        end
        else if (n == 1)
            op = OP_RELEASE;
        else if (n == 2)
            op = OP_PUBLISH;
        else if (n == 3)
            op = OP_QUERY;
        else if (n == 4)
        begin
            op  = op_t'(5);
            idx = '0;
        end
        else if (n == 5)
            op = op_t'(7);
        else if (n < 6 + SLOTS + 1)
            op = OP_RESERVE;
        else
            op = OP_PUBLISH;
    endtask

    // Random item: mostly well-formed traffic, some noise
    task automatic random_item(output op_t op, output idx_t idx);
        int  pick;
        int  k;
        bit  noise;
        pick  = $urandom_range(99);
        noise = ($urandom_range(99) < 12);
        idx   = idx_t'($urandom_range(SLOTS - 1));
        if (pick < 27)
            op = OP_RESERVE;
        else if (pick < 52)
            op = OP_PUBLISH;
        else if (pick < 74)
            op = OP_TAKE;
        else if (pick < 94)
            op = OP_RELEASE;
        else
            op = op_t'($urandom_range(7, 4));
        if (!noise && op == OP_PUBLISH && to_publish.size() > 0)
        begin
            k   = $urandom_range(to_publish.size() - 1);
            idx = to_publish[k];
            to_publish.delete(k);
        end
        else if (!noise && op == OP_RELEASE && to_release.size() > 0)
        begin
            k   = $urandom_range(to_release.size() - 1);
            idx = to_release[k];
            to_release.delete(k);
        end
    endtask

    // Drive request beats and response stalls
    always @(posedge clk or negedge rst_n)
    begin : drive
        op_t  op;
        op_t  done_op;
        idx_t idx;
        bit   quiet;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
            sent = 0;
            in_flight.delete();
            to_publish.delete();
            to_release.delete();
        end
        else
        begin
            // track granted slots from ok responses
            if (rsp_ch.valid && rsp_ch.ready && in_flight.size() > 0)
            begin
                done_op = in_flight.pop_front();
                if (rsp_ch.status == ST_OK && done_op == OP_RESERVE)
                    to_publish.push_back(rsp_ch.granted_slot);
                else if (rsp_ch.status == ST_OK && done_op == OP_TAKE)
                    to_release.push_back(rsp_ch.granted_slot);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                in_flight.push_back(req_ch.opcode);
                sent++;
            end
            quiet = (sent >= 400 && sent < 700);
            // advance to the next beat unless one is still held
            if (!req_ch.valid || req_ch.ready)
            begin
                if (sent < ITEMS && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    if (sent < DIRECTED)
                        directed_item(sent, op, idx);
                    else
                        random_item(op, idx);
                    req_ch.opcode     <= op;
                    req_ch.slot_index <= idx;
                    req_ch.valid      <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** sequenced_slot_ring_queue: FAILED **");
            $finish;
        end
    end

    // Reset, wait for the drain, give the verdict
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (sent < ITEMS)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** sequenced_slot_ring_queue: PASSED **");
        else
            $display("** sequenced_slot_ring_queue: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ssrq_pkg.sv
design/ssrq_if.sv
design/sequenced_slot_ring_queue.sv
verif/ssrq_response_checker.sv
verif/sequenced_slot_ring_queue_tb.sv
